>>> rtl/nasrt_pkg.sv
`timescale 1ns / 1ps

package nasrt_pkg;

	// Fixed field widths of the stream words.
	localparam int LABEL_W   = 6;
	localparam int FRAC_W    = 16;
	localparam int COEF_W    = 18;
	localparam int TOTAL_W   = 24;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 48;
	localparam int STEP_W    = 4;

	// Defaults for the top-level parameters.
	localparam int NUM_CLASSES_DEF = 64;
	localparam int COUNT_WIDTH_DEF = 24;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc_rd;    // read the three tables at the incoming labels
		logic upd;       // write back the incremented counts
		logic red_rd;    // read one entry for the reduction, clear it
		logic clr_wr;    // clear one entry after reset
		logic mul_diag;  // product m * sum diag
		logic mul_sq;    // product m * m
		logic sub_den;   // denominator and sign
		logic sub_mag;   // numerator magnitude
		logic div_init;  // range checks, load remainder
		logic div_step;  // one quotient bit
		logic load_out;  // move the result to the output register
	} nasrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_full;
	} nasrt_sts_t;

endpackage

>>> rtl/nasrt_ctrl.sv
`timescale 1ns / 1ps

module nasrt_ctrl import nasrt_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	localparam int CLS_W = $clog2(NUM_CLASSES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	output logic             s_tready,
	input  nasrt_sts_t       sts,
	output nasrt_cmd_t       cmd,
	output logic [CLS_W-1:0] addr
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_UPD  = 4'd2;
	localparam logic [3:0] S_RED  = 4'd3;
	localparam logic [3:0] S_DRN  = 4'd4;
	localparam logic [3:0] S_MUL1 = 4'd5;
	localparam logic [3:0] S_MUL2 = 4'd6;
	localparam logic [3:0] S_SUB1 = 4'd7;
	localparam logic [3:0] S_SUB2 = 4'd8;
	localparam logic [3:0] S_CMP  = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	localparam logic [CLS_W-1:0]  ADDR_LAST = CLS_W'(NUM_CLASSES - 1);
	localparam logic [STEP_W-1:0] DRN_LAST  = STEP_W'(1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(FRAC_W - 1);

	logic [3:0]        state_q, state_d;
	logic [CLS_W-1:0]  addr_q, addr_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              last_q, last_d;

	assign addr = addr_q;

	// Next-state and command decode.
	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		step_d   = step_q;
		last_d   = last_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == ADDR_LAST) begin
					addr_d  = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.acc_rd = 1'b1;
					last_d  = s_tlast;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				addr_d  = '0;
				state_d = last_q ? S_RED : S_IDLE;
			end
			S_RED: begin
				cmd.red_rd = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == ADDR_LAST) begin
					addr_d  = '0;
					step_d  = '0;
					state_d = S_DRN;
				end
			end
			S_DRN: begin
				step_d = step_q + 1'b1;
				if (step_q == DRN_LAST) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_diag = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_sq = 1'b1;
				state_d = S_SUB1;
			end
			S_SUB1: begin
				cmd.sub_den = 1'b1;
				state_d = S_SUB2;
			end
			S_SUB2: begin
				cmd.sub_mag = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.div_init = 1'b1;
				step_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == DIV_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					last_d  = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers; reset starts with a clearing sweep of the tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			addr_q  <= '0;
			step_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			step_q  <= step_d;
			last_q  <= last_d;
		end
	end

endmodule

>>> rtl/nasrt_dp.sv
`timescale 1ns / 1ps

module nasrt_dp import nasrt_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	localparam int CLS_W = $clog2(NUM_CLASSES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [LABEL_W-1:0]   label_src,
	input  logic [LABEL_W-1:0]   label_dst,
	input  nasrt_cmd_t           cmd,
	input  logic [CLS_W-1:0]     addr,
	output nasrt_sts_t           sts,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [M_TDATA_W-1:0] out_data
);

	localparam int CW  = COUNT_WIDTH;
	localparam int CW2 = 2 * COUNT_WIDTH;
	localparam logic [CW-1:0] COUNT_MAX = '1;

	// Count tables.
	logic [CW-1:0] src_mem  [NUM_CLASSES];
	logic [CW-1:0] tgt_mem  [NUM_CLASSES];
	logic [CW-1:0] same_mem [NUM_CLASSES];
	logic [CW-1:0] src_rd_q, tgt_rd_q, same_rd_q;

	logic [CLS_W-1:0] src_s1, dst_s1;
	logic             inr_s1;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q;

	logic [CLS_W-1:0] ra_src, ra_tgt, wa_src, wa_tgt;
	logic             rd_en, count_ok, clr_en;
	logic             we_src, we_tgt, we_same;
	logic [CW-1:0]    wd_src, wd_tgt, wd_same;

	// Reduction pipeline.
	logic           v_s1, v_s2;
	logic [CW2-1:0] prod_s2;
	logic [CW-1:0]  diag_s2;
	logic [CW-1:0]  diag_q;
	logic [CW2-1:0] ab_q;

	// Final arithmetic.
	logic [CW-1:0]   mul_b;
	logic [CW2-1:0]  mul_p;
	logic [CW2-1:0]  mdiag_q, mm_q, den_q, mag_q, rem_q;
	logic            neg_q, sat_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CW2:0]    rem2;
	logic            rem_ge;

	// Output register.
	logic              m_valid_q;
	logic [COEF_W-1:0] coef_q, coef_d;
	logic              undef_q;
	logic              ovf_out_q;
	logic [TOTAL_W-1:0] total_q;
	logic [31:0]       cnt32;

	// Table addressing: labels while counting, the sweep address otherwise.
	assign ra_src   = cmd.acc_rd ? CLS_W'(label_src) : addr;
	assign ra_tgt   = cmd.acc_rd ? CLS_W'(label_dst) : addr;
	assign rd_en    = cmd.acc_rd | cmd.red_rd;
	assign count_ok = inr_s1 && (cnt_q != COUNT_MAX);
	assign clr_en   = cmd.red_rd | cmd.clr_wr;
	assign wa_src   = cmd.upd ? src_s1 : addr;
	assign wa_tgt   = cmd.upd ? dst_s1 : addr;
	assign we_src   = clr_en | (cmd.upd & count_ok);
	assign we_tgt   = we_src;
	assign we_same  = clr_en | (cmd.upd & count_ok & (src_s1 == dst_s1));
	assign wd_src   = clr_en ? '0 : src_rd_q + 1'b1;
	assign wd_tgt   = clr_en ? '0 : tgt_rd_q + 1'b1;
	assign wd_same  = clr_en ? '0 : same_rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (we_src) begin
			src_mem[wa_src] <= wd_src;
		end
		if (rd_en) begin
			src_rd_q <= src_mem[ra_src];
		end
	end

	always_ff @(posedge clk) begin
		if (we_tgt) begin
			tgt_mem[wa_tgt] <= wd_tgt;
		end
		if (rd_en) begin
			tgt_rd_q <= tgt_mem[ra_tgt];
		end
	end

	always_ff @(posedge clk) begin
		if (we_same) begin
			same_mem[wa_src] <= wd_same;
		end
		if (rd_en) begin
			same_rd_q <= same_mem[ra_src];
		end
	end

	// Incoming word registers.
	always_ff @(posedge clk) begin
		if (cmd.acc_rd) begin
			src_s1 <= CLS_W'(label_src);
			dst_s1 <= CLS_W'(label_dst);
			inr_s1 <= (32'(label_src) < NUM_CLASSES) && (32'(label_dst) < NUM_CLASSES);
		end
	end

	// Edge counter with saturation and sticky overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load_out) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.upd && inr_s1) begin
			if (count_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Reduction: one entry per cycle, product registered before the sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			diag_q <= '0;
			ab_q   <= '0;
		end else begin
			v_s1 <= cmd.red_rd;
			v_s2 <= v_s1;
			if (cmd.load_out) begin
				diag_q <= '0;
				ab_q   <= '0;
			end else if (v_s2) begin
				diag_q <= diag_q + diag_s2;
				ab_q   <= ab_q + prod_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= CW2'(src_rd_q) * CW2'(tgt_rd_q);
		diag_s2 <= same_rd_q;
	end

	// Shared multiplier for m*diag and m*m.
	assign mul_b = cmd.mul_sq ? cnt_q : diag_q;
	assign mul_p = CW2'(cnt_q) * CW2'(mul_b);

	// Restoring division step on the remainder.
	assign rem2   = {rem_q, 1'b0};
	assign rem_ge = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_diag) begin
			mdiag_q <= mul_p;
		end
		if (cmd.mul_sq) begin
			mm_q <= mul_p;
		end
		if (cmd.sub_den) begin
			den_q <= mm_q - ab_q;
			neg_q <= ab_q > mdiag_q;
		end
		if (cmd.sub_mag) begin
			mag_q <= neg_q ? ab_q - mdiag_q : mdiag_q - ab_q;
		end
		if (cmd.div_init) begin
			sat_q  <= mag_q >= den_q;
			rem_q  <= mag_q;
			frac_q <= '0;
		end else if (cmd.div_step) begin
			frac_q <= {frac_q[FRAC_W-2:0], rem_ge};
			rem_q  <= rem_ge ? CW2'(rem2 - {1'b0, den_q}) : CW2'(rem2);
		end
	end

	// Result formatting: zero when undefined, +-1.0 when saturated.
	always_comb begin
		if (den_q == '0) begin
			coef_d = '0;
		end else if (sat_q) begin
			coef_d = COEF_W'(1) << FRAC_W;
		end else begin
			coef_d = COEF_W'(frac_q);
		end
		if (neg_q) begin
			coef_d = -coef_d;
		end
	end

	assign cnt32 = 32'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			coef_q    <= coef_d;
			undef_q   <= (den_q == '0);
			ovf_out_q <= ovf_q;
			total_q   <= cnt32[TOTAL_W-1:0];
		end
	end

	assign sts.out_full = m_valid_q;
	assign out_valid    = m_valid_q;
	assign out_data     = M_TDATA_W'({total_q, ovf_out_q, undef_q, coef_q});

	// A result is never loaded over one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !m_valid_q)
		else $error("result loaded while output register full");

	// The same-class sum can never exceed the edge count.
	a_diag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_diag |-> diag_q <= cnt_q)
		else $error("diagonal sum exceeds edge count");

	// In a regular division the remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sat_q && den_q != '0) |-> rem_q < den_q)
		else $error("division remainder out of range");

endmodule

>>> rtl/nominal_assortativity.sv
`timescale 1ns / 1ps
// An edge is handled as a table read, then a write-back of the counts.
// A new edge is accepted only after that write-back, set by the read-modify-write of the tables.
// On the last edge the result follows a reduction of one table entry per cycle,
// then two products, two subtractions and a 16-bit restoring division.
// Reset is asynchronous; afterwards a clearing sweep of all NUM_CLASSES table entries runs
// before the first word is accepted.

module nominal_assortativity import nasrt_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// class_source [5:0], class_target [11:6], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// coefficient [17:0], undefined [18], overflow [19], edge_total [43:20], zero fill
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int CLS_W = $clog2(NUM_CLASSES);

	nasrt_cmd_t       cmd;
	nasrt_sts_t       sts;
	logic [CLS_W-1:0] addr;

	nasrt_ctrl #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.addr     (addr)
	);

	nasrt_dp #(
		.NUM_CLASSES(NUM_CLASSES),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.label_src (s_tdata[LABEL_W-1:0]),
		.label_dst (s_tdata[2*LABEL_W-1:LABEL_W]),
		.cmd       (cmd),
		.addr      (addr),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
